// ===== rtl/clcd_pkg.sv =====
// ============================================================================
// clcd_pkg - character LCD write sequencer shared definitions
// Request codes, HD44780 command bytes, delays and internal bundle types.
// ============================================================================
package clcd_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;

    localparam logic [2:0] ACT_INIT   = 3'd0;
    localparam logic [2:0] ACT_CLEAR  = 3'd1;
    localparam logic [2:0] ACT_CHAR   = 3'd2;
    localparam logic [2:0] ACT_GOTO   = 3'd3;
    localparam logic [2:0] ACT_NUMBER = 3'd4;
    localparam logic [2:0] ACT_BLANK  = 3'd5;

    localparam logic [7:0] CMD_WAKE4   = 8'h33;
    localparam logic [7:0] CMD_SET4    = 8'h32;
    localparam logic [7:0] CMD_FUNC4   = 8'h28;
    localparam logic [7:0] CMD_FUNC8   = 8'h38;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_DISP_ON = 8'h0C;
    localparam logic [7:0] CMD_ROW1    = 8'h80;
    localparam logic [7:0] CMD_ROW2    = 8'hC0;

    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [3:0] CHR_DIGIT_HI = 4'h3;

    localparam logic [13:0] WAIT_POWERUP = 14'd15000;
    localparam logic [10:0] WAIT_SHORT   = 11'd100;
    localparam logic [10:0] WAIT_LONG    = 11'd2000;

    localparam logic [2:0] INIT_LEN4 = 3'd6;
    localparam logic [2:0] INIT_LEN8 = 3'd4;

    typedef struct packed {
        logic        rs;
        logic [7:0]  data;
        logic [13:0] wait_pre;
        logic [10:0] after;
        logic        last;
    } t_req;

    typedef struct packed {
        logic       busy;
        logic [3:0] digit;
        logic [3:0] left;
    } t_bcd_st;

    typedef struct packed {
        logic [7:0]  data;
        logic [10:0] after;
    } t_init_ent;

    function automatic t_init_ent init_entry(input logic mode8, input logic [2:0] idx);
        t_init_ent e;
        e = '{data: CMD_DISP_ON, after: WAIT_SHORT};
        if (mode8) begin
            unique case (idx)
                3'd0:    e = '{data: CMD_FUNC8,   after: WAIT_SHORT};
                3'd1:    e = '{data: CMD_DISP_ON, after: WAIT_SHORT};
                3'd2:    e = '{data: CMD_CLEAR,   after: WAIT_LONG};
                3'd3:    e = '{data: CMD_HOME,    after: WAIT_LONG};
                default: e = '{data: CMD_DISP_ON, after: WAIT_SHORT};
            endcase
        end else begin
            unique case (idx)
                3'd0:    e = '{data: CMD_WAKE4,   after: WAIT_SHORT};
                3'd1:    e = '{data: CMD_SET4,    after: WAIT_SHORT};
                3'd2:    e = '{data: CMD_FUNC4,   after: WAIT_SHORT};
                3'd3:    e = '{data: CMD_CLEAR,   after: WAIT_LONG};
                3'd4:    e = '{data: CMD_HOME,    after: WAIT_LONG};
                default: e = '{data: CMD_DISP_ON, after: WAIT_SHORT};
            endcase
        end
        return e;
    endfunction

endpackage

// ===== rtl/clcd_bcd.sv =====
// ============================================================================
// clcd_bcd - bit-serial binary to BCD converter
// Shift-and-add-3 over all 32 input bits, then hands out digits MSD first, one per pop.
// ============================================================================
module clcd_bcd
    import clcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_bin,
    input  logic               i_pop,
    output t_bcd_st            o_st
);

    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam int CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic [3:0]         r_left;
    logic [BCD_W-1:0]   w_adj;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                         : r_bcd[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_left <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                r_busy <= 1'b0;
                r_left <= 4'(NUM_DIGITS);
            end
        end else if (i_pop) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        end else if (i_pop) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'b0};
        end
    end

    assign o_st = '{busy: r_busy, digit: r_bcd[BCD_W-1 -: 4], left: r_left};

    a_pop_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (!r_busy && r_left != 4'd0))
        else $error("digit pop while converting or empty");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_cnt == '0))
        else $error("conversion did not start");

endmodule

// ===== rtl/clcd_strobe.sv =====
// ============================================================================
// clcd_strobe - byte to bus strobe emitter
// Holds one byte transaction and sends it as one 8-bit or two nibble strobes.
// ============================================================================
module clcd_strobe
    import clcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mode8,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic        o_rs,
    output logic [7:0]  o_data,
    output logic [13:0] o_before,
    output logic [10:0] o_after,
    output logic        o_last
);

    logic r_full;
    logic r_half;
    t_req r_req;
    logic w_finish;
    logic w_out_hs;

    assign w_finish    = i_mode8 || r_half;
    assign w_out_hs    = r_full && i_tready;
    assign o_req_ready = !r_full || (w_out_hs && w_finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_half <= 1'b0;
        end else if (i_req_valid && o_req_ready) begin
            r_full <= 1'b1;
            r_half <= 1'b0;
        end else if (w_out_hs) begin
            if (w_finish) begin
                r_full <= 1'b0;
                r_half <= 1'b0;
            end else begin
                r_half <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
    end

    always_comb begin
        o_rs = r_req.rs;
        if (i_mode8) begin
            o_data   = r_req.data;
            o_before = r_req.wait_pre;
            o_after  = r_req.after;
            o_last   = r_req.last;
        end else if (!r_half) begin
            o_data   = {4'b0, r_req.data[7:4]};
            o_before = r_req.wait_pre;
            o_after  = '0;
            o_last   = 1'b0;
        end else begin
            o_data   = {4'b0, r_req.data[3:0]};
            o_before = '0;
            o_after  = r_req.after;
            o_last   = r_req.last;
        end
    end

    assign o_tvalid = r_full;

    a_half_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_full)
        else $error("low nibble pending without a byte");

endmodule

// ===== rtl/char_lcd_parallel_write_sequencer.sv =====
// ============================================================================
// char_lcd_parallel_write_sequencer - HD44780 style request to strobe sequencer
// Expands one LCD request into enable strobes for a 4-bit or 8-bit bus.
// ============================================================================
// Flow: a request is registered into the sequencer state, then into the strobe
//   stage that drives the first strobe; numbers run the bit-serial BCD conversion
//   first, then skip leading zeros (up to 9) before the first digit.
// Throughput: one strobe per cycle while the sink is ready; one request at a
//   time, next request taken once the last byte has moved to the strobe stage.
// Reset: synchronous active low; sequencer goes idle, bus mode returns to 4-bit.
module char_lcd_parallel_write_sequencer
    import clcd_pkg::*;
#(
    parameter int NUM_COLUMNS = 16,
    parameter int MAX_BLANKS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // char_code, row, column, value, zero pad
    input  logic [2:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // bus_value, wait_before_us, wait_after_us, pad
    output logic [0:0]  m_axis_tuser,  // register_select
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_BLANKS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ONE   = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_CONV  = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_SKIP  = 3'd5;
    localparam logic [2:0] S_DIGIT = 3'd6;
    localparam logic [2:0] S_BLANK = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_step,  n_step;
    logic [7:0]       r_byte,  n_byte;
    logic             r_rs,    n_rs;
    logic [10:0]      r_after, n_after;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_neg,   n_neg;
    logic             r_mode;

    logic [7:0]         w_char;
    logic [1:0]         w_row;
    logic [6:0]         w_col;
    logic [VALUE_W-1:0] w_value;
    logic               w_accept;
    logic               w_char_ok;
    logic               w_goto_ok;
    logic               w_neg;
    logic [VALUE_W-1:0] w_mag;
    logic [CNT_W-1:0]   w_blanks;
    t_init_ent          w_ent;
    logic [2:0]         w_init_len;
    logic               w_skip;

    t_req    req;
    logic    req_valid;
    logic    req_ready;
    logic    req_hs;
    t_bcd_st bcd_st;
    logic    bcd_pop;

    logic [7:0]  w_bus;
    logic [13:0] w_before;
    logic [10:0] w_after;
    logic        w_rs;

    assign w_char  = s_axis_tdata[7:0];
    assign w_row   = s_axis_tdata[9:8];
    assign w_col   = s_axis_tdata[16:10];
    assign w_value = s_axis_tdata[48:17];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_char_ok = (w_char != 8'd0) && !w_char[7];
    assign w_goto_ok = (w_col < 7'(NUM_COLUMNS)) && (w_row == 2'd1 || w_row == 2'd2);
    assign w_neg     = w_value[VALUE_W-1];
    assign w_mag     = w_neg ? ('0 - w_value) : w_value;

    always_comb begin
        if (w_neg) begin
            w_blanks = '0;
        end else if (w_value[VALUE_W-2:0] > (VALUE_W-1)'(MAX_BLANKS)) begin
            w_blanks = CNT_W'(MAX_BLANKS);
        end else begin
            w_blanks = w_value[CNT_W-1:0];
        end
    end

    assign w_ent      = init_entry(r_mode, r_step);
    assign w_init_len = r_mode ? INIT_LEN8 : INIT_LEN4;
    assign w_skip     = (bcd_st.digit == 4'd0) && (bcd_st.left > 4'd1);
    assign req_hs     = req_valid && req_ready;
    assign bcd_pop    = ((r_state == S_SKIP) && w_skip) || ((r_state == S_DIGIT) && req_hs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    always_comb begin
        req_valid = 1'b0;
        req       = '0;
        unique case (r_state)
            S_ONE: begin
                req_valid = 1'b1;
                req       = '{rs: r_rs, data: r_byte, wait_pre: '0, after: r_after,
                              last: 1'b1};
            end
            S_INIT: begin
                req_valid    = 1'b1;
                req.data     = w_ent.data;
                req.after    = w_ent.after;
                req.wait_pre = (r_step == 3'd0) ? WAIT_POWERUP : 14'd0;
                req.last     = (r_step == w_init_len - 3'd1);
            end
            S_SIGN: begin
                req_valid = 1'b1;
                req.rs    = 1'b1;
                req.data  = CHR_MINUS;
            end
            S_DIGIT: begin
                req_valid = 1'b1;
                req.rs    = 1'b1;
                req.data  = {CHR_DIGIT_HI, bcd_st.digit};
                req.last  = (bcd_st.left == 4'd1);
            end
            S_BLANK: begin
                req_valid = 1'b1;
                req.rs    = 1'b1;
                req.data  = CHR_SPACE;
                req.last  = (r_cnt == CNT_W'(1));
            end
            default: begin
                req_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_byte  = r_byte;
        n_rs    = r_rs;
        n_after = r_after;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (s_axis_tuser)
                        ACT_INIT: begin
                            n_state = S_INIT;
                            n_step  = 3'd0;
                        end
                        ACT_CLEAR: begin
                            n_state = S_ONE;
                            n_byte  = CMD_CLEAR;
                            n_rs    = 1'b0;
                            n_after = WAIT_LONG;
                        end
                        ACT_CHAR: begin
                            if (w_char_ok) begin
                                n_state = S_ONE;
                                n_byte  = w_char;
                                n_rs    = 1'b1;
                                n_after = '0;
                            end
                        end
                        ACT_GOTO: begin
                            if (w_goto_ok) begin
                                n_state = S_ONE;
                                n_byte  = ((w_row == 2'd1) ? CMD_ROW1 : CMD_ROW2)
                                          + {1'b0, w_col};
                                n_rs    = 1'b0;
                                n_after = '0;
                            end
                        end
                        ACT_NUMBER: begin
                            n_state = S_CONV;
                            n_neg   = w_neg;
                        end
                        ACT_BLANK: begin
                            if (w_blanks != '0) begin
                                n_state = S_BLANK;
                                n_cnt   = w_blanks;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ONE: begin
                if (req_hs) begin
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                if (req_hs) begin
                    if (req.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_CONV: begin
                if (!bcd_st.busy) begin
                    n_state = r_neg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN: begin
                if (req_hs) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!w_skip) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (req_hs && req.last) begin
                    n_state = S_IDLE;
                end
            end
            S_BLANK: begin
                if (req_hs) begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (req.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_rs    <= n_rs;
        r_after <= n_after;
    end

    clcd_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (s_axis_tuser == ACT_NUMBER)),
        .i_bin   (w_mag),
        .i_pop   (bcd_pop),
        .o_st    (bcd_st)
    );

    clcd_strobe u_strobe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode8     (r_mode),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_rs        (w_rs),
        .o_data      (w_bus),
        .o_before    (w_before),
        .o_after     (w_after),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, w_after, w_before, w_bus};
    assign m_axis_tuser = w_rs;

    a_digit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT || r_state == S_SKIP) |-> (!bcd_st.busy && bcd_st.left != 4'd0))
        else $error("digit state without converted digits");

    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_hs && req.last) |=> (r_state == S_IDLE))
        else $error("request did not end on its last byte");

endmodule
